/* hw/rtl/flash_settings_save_sequencer_top_assert.svh */
// ---------------------------------------------------------------------------
// flash_settings_save_sequencer_top_assert.svh
// Assertion macros for the save sequencer.
// ---------------------------------------------------------------------------
`ifndef FLASH_SETTINGS_SAVE_SEQUENCER_TOP_ASSERT_SVH
`define FLASH_SETTINGS_SAVE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define FSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fss_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fss_pkg
// Shared constants and types for the flash settings save sequencer.
// ---------------------------------------------------------------------------
package fss_pkg;

    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_COUNT = 512;

    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    localparam int SECTOR_W    = $clog2(SECTOR_COUNT);
    localparam int COMMON_W    = 13;
    localparam int MODELS_W    = 14;
    localparam int ADDR_W      = 21;
    localparam int OFFSET_W    = 13;
    localparam int COUNT_W     = 9;
    localparam int INDEX_W     = 6;
    localparam int PHASE_W     = 4;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    // size / offset arithmetic: page offset and sizes plus one bit of headroom
    localparam int CALC_W      = INDEX_W + PAGE_SHIFT + 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SNAP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PROGRAM = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BACKUP_SECTOR  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRIMARY_SECTOR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MODELS_SECTOR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMON_BYTES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MODELS_BYTES   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic                region;
        logic [ADDR_W-1:0]   flash_address;
        logic [OFFSET_W-1:0] source_offset;
        logic [COUNT_W-1:0]  byte_count;
        logic                saving;
    } result_t;

endpackage

/* hw/rtl/flash_settings_save_sequencer_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flash_settings_save_sequencer_top
// Save sequencer: snapshot, then erase/program backup, primary and model
// sectors page by page, polling the flash busy bit between commands.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | save_request, flash_busy
//  out     | out_valid / out_stall| command, region, flash_address,
//          |                      | source_offset, byte_count, saving
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while in_stall is low. Each accepted item advances the
//  phase machine once; its result, computed in the same cycle, is registered
//  into the output register, or into the skid while the output is held. The
//  two-entry output stage (output register plus skid) keeps input accepting
//  while a result waits; in_stall rises only when the skid entry is occupied.
//  Reset clears the phase machine, the request latch and the output valids;
//  config registers reset to their defaults.
module flash_settings_save_sequencer_top
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            save_request,
    input  logic                            flash_busy,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [fss_pkg::CMD_W-1:0]       command,
    output logic                            region,
    output logic [fss_pkg::ADDR_W-1:0]      flash_address,
    output logic [fss_pkg::OFFSET_W-1:0]    source_offset,
    output logic [fss_pkg::COUNT_W-1:0]     byte_count,
    output logic                            saving,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // phase codes
    localparam logic [fss_pkg::PHASE_W-1:0] PH_IDLE         = 4'd0;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_SNAP         = 4'd1;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_ERASE_B      = 4'd2;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WAIT_ERASE_B = 4'd3;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WRITE_B      = 4'd4;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WAIT_WRITE_B = 4'd5;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_ERASE_A      = 4'd6;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WAIT_ERASE_A = 4'd7;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WRITE_A      = 4'd8;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WAIT_WRITE_A = 4'd9;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_ERASE_M      = 4'd10;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WAIT_ERASE_M = 4'd11;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WRITE_M      = 4'd12;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_WAIT_WRITE_M = 4'd13;
    localparam logic [fss_pkg::PHASE_W-1:0] PH_DONE         = 4'd14;

    localparam int W = fss_pkg::CALC_W;

    // ---------------- configuration registers ----------------
    logic [fss_pkg::SECTOR_W-1:0] backup_sector_reg;
    logic [fss_pkg::SECTOR_W-1:0] primary_sector_reg;
    logic [fss_pkg::SECTOR_W-1:0] models_sector_reg;
    logic [fss_pkg::COMMON_W-1:0] common_bytes_reg;
    logic [fss_pkg::MODELS_W-1:0] models_bytes_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backup_sector_reg  <= fss_pkg::SECTOR_W'(0);
            primary_sector_reg <= fss_pkg::SECTOR_W'(1);
            models_sector_reg  <= fss_pkg::SECTOR_W'(2);
            common_bytes_reg   <= fss_pkg::COMMON_W'(256);
            models_bytes_reg   <= fss_pkg::MODELS_W'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fss_pkg::REG_BACKUP_SECTOR:
                    backup_sector_reg <= cfg_data[fss_pkg::SECTOR_W-1:0];
                fss_pkg::REG_PRIMARY_SECTOR:
                    primary_sector_reg <= cfg_data[fss_pkg::SECTOR_W-1:0];
                fss_pkg::REG_MODELS_SECTOR:
                    models_sector_reg <= cfg_data[fss_pkg::SECTOR_W-1:0];
                fss_pkg::REG_COMMON_BYTES:
                    common_bytes_reg <= cfg_data[fss_pkg::COMMON_W-1:0];
                fss_pkg::REG_MODELS_BYTES:
                    models_bytes_reg <= cfg_data[fss_pkg::MODELS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    logic [fss_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                        request_pending_reg, request_pending_next;
    logic [fss_pkg::INDEX_W-1:0] page_index_reg, page_index_next;
    logic [fss_pkg::INDEX_W-1:0] page_total_reg, page_total_next;

    logic in_fire;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;

    // Shared page-program datapath: the active write phase picks its sector
    // and block size, one offset/remaining/chunk calculation serves all three.
    logic [fss_pkg::SECTOR_W-1:0] wr_sector;
    logic [W-1:0]                 wr_size;
    logic [W-1:0]                 wr_offset;
    logic [W-1:0]                 wr_remain;
    logic [W-1:0]                 wr_chunk;
    logic [fss_pkg::ADDR_W-1:0]   wr_page_addr;
    logic [fss_pkg::ADDR_W-1:0]   erase_addr;
    logic [fss_pkg::SECTOR_W-1:0] erase_sector;
    logic [W-1:0]                 models_pages;

    always_comb
    begin
        case (phase_reg)
            PH_WRITE_A:
            begin
                wr_sector = primary_sector_reg;
                wr_size   = W'(common_bytes_reg);
            end
            PH_WRITE_M:
            begin
                wr_sector = models_sector_reg;
                wr_size   = W'(models_bytes_reg);
            end
            default:
            begin
                wr_sector = backup_sector_reg;
                wr_size   = W'(common_bytes_reg);
            end
        endcase

        case (phase_reg)
            PH_ERASE_A: erase_sector = primary_sector_reg;
            PH_ERASE_M: erase_sector = models_sector_reg;
            default:    erase_sector = backup_sector_reg;
        endcase
    end

    assign wr_offset = W'(page_index_reg) << fss_pkg::PAGE_SHIFT;
    assign wr_remain = (wr_size > wr_offset) ? (wr_size - wr_offset) : W'(0);
    assign wr_chunk  = (wr_remain < W'(fss_pkg::PAGE_BYTES)) ?
                       wr_remain : W'(fss_pkg::PAGE_BYTES);

    // page address = (first page of sector + index) * page size, 21-bit wrap
    assign wr_page_addr =
        (((fss_pkg::ADDR_W'(wr_sector) << fss_pkg::SECTOR_SHIFT) >> fss_pkg::PAGE_SHIFT)
         + fss_pkg::ADDR_W'(page_index_reg)) << fss_pkg::PAGE_SHIFT;
    assign erase_addr = fss_pkg::ADDR_W'(erase_sector) << fss_pkg::SECTOR_SHIFT;

    // ceil(models_bytes / page)
    assign models_pages = (W'(models_bytes_reg) + W'(fss_pkg::PAGE_BYTES - 1))
                          >> fss_pkg::PAGE_SHIFT;

    fss_pkg::result_t res;

    always_comb
    begin
        phase_next           = phase_reg;
        request_pending_next = request_pending_reg | save_request;
        page_index_next      = page_index_reg;
        page_total_next      = page_total_reg;
        res                  = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (request_pending_next)
                begin
                    request_pending_next = 1'b0;
                    phase_next           = PH_SNAP;
                end
            end
            PH_SNAP:
            begin
                res.command = fss_pkg::CMD_SNAP;
                phase_next  = PH_ERASE_B;
            end
            PH_ERASE_B, PH_ERASE_A, PH_ERASE_M:
            begin
                res.command       = fss_pkg::CMD_ERASE;
                res.flash_address = erase_addr;
                phase_next        = phase_reg + fss_pkg::PHASE_W'(1);
            end
            PH_WAIT_ERASE_B, PH_WAIT_ERASE_A:
            begin
                if (!flash_busy)
                begin
                    page_index_next = '0;
                    phase_next      = phase_reg + fss_pkg::PHASE_W'(1);
                end
            end
            PH_WAIT_ERASE_M:
            begin
                if (!flash_busy)
                begin
                    page_index_next = '0;
                    page_total_next = models_pages[fss_pkg::INDEX_W-1:0];
                    phase_next      = PH_WRITE_M;
                end
            end
            PH_WRITE_B, PH_WRITE_A, PH_WRITE_M:
            begin
                // common blocks stop on zero remaining, models on page count
                if ((phase_reg == PH_WRITE_M) ? (page_index_reg >= page_total_reg)
                                              : (wr_remain == W'(0)))
                begin
                    case (phase_reg)
                        PH_WRITE_B: phase_next = PH_ERASE_A;
                        PH_WRITE_A: phase_next = PH_ERASE_M;
                        default:    phase_next = PH_DONE;
                    endcase
                end
                else
                begin
                    res.command       = fss_pkg::CMD_PROGRAM;
                    res.region        = (phase_reg == PH_WRITE_M);
                    res.flash_address = wr_page_addr;
                    res.source_offset = wr_offset[fss_pkg::OFFSET_W-1:0];
                    res.byte_count    = wr_chunk[fss_pkg::COUNT_W-1:0];
                    phase_next        = phase_reg + fss_pkg::PHASE_W'(1);
                end
            end
            PH_WAIT_WRITE_B, PH_WAIT_WRITE_A, PH_WAIT_WRITE_M:
            begin
                if (!flash_busy)
                begin
                    page_index_next = page_index_reg + fss_pkg::INDEX_W'(1);
                    phase_next      = phase_reg - fss_pkg::PHASE_W'(1);
                end
            end
            default:
            begin
                // done and unused codes
                phase_next = PH_IDLE;
            end
        endcase

        res.saving = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            request_pending_reg <= 1'b0;
            page_index_reg      <= '0;
            page_total_reg      <= '0;
        end
        else if (in_fire)
        begin
            phase_reg           <= phase_next;
            request_pending_reg <= request_pending_next;
            page_index_reg      <= page_index_next;
            page_total_reg      <= page_total_next;
        end
    end

    // ---------------- output register + skid ----------------
    fss_pkg::result_t out_reg;
    fss_pkg::result_t skid_reg;
    logic             out_load;

    assign out_load = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= skid_valid_reg || in_fire;
            end
            if (skid_valid_reg && !out_stall)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire && !out_load)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (in_fire && !out_load)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = out_reg.command;
    assign region        = out_reg.region;
    assign flash_address = out_reg.flash_address;
    assign source_offset = out_reg.source_offset;
    assign byte_count    = out_reg.byte_count;
    assign saving        = out_reg.saving;

    // ---------------- assertions ----------------
`include "flash_settings_save_sequencer_top_assert.svh"

    // skid entry only fills behind a held output
    `FSS_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid valid without output valid")
    // a page program never carries an empty chunk
    `FSS_ASSERT_IMPL(a_program_nonempty, clk, rst_n, out_valid_reg && (command == fss_pkg::CMD_PROGRAM), byte_count != '0, "program item with zero byte count")
    // erase items come from inside a running sequence
    `FSS_ASSERT_IMPL(a_erase_saving, clk, rst_n, out_valid_reg && (command == fss_pkg::CMD_ERASE), saving, "erase item while not saving")
    // a request during a sequence stays latched
    `FSS_ASSERT_NEXT(a_request_held, clk, rst_n, in_fire && save_request && (phase_reg != PH_IDLE), request_pending_reg, "save request lost while busy")

endmodule
